@@ hw/rtl/dcc_pkt_pkg.sv @@
// ----------------------------------------------------------------------------
// dcc_pkt_pkg
// Shared types and constants for the DCC locomotive packet builder.
// ----------------------------------------------------------------------------
package dcc_pkt_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] LONG_ADDR_PREFIX = 8'hC0;
  localparam logic [7:0] SPEED_INSTR      = 8'h3F;
  localparam logic [7:0] ESTOP_BYTE       = 8'h01;
  localparam logic [6:0] SPEED_MAX        = 7'd126;
  localparam logic [2:0] FG1_PREFIX       = 3'b100;   // 0x80 group
  localparam logic [3:0] FG2_PREFIX       = 4'hB;     // 0xB0 group
  localparam logic [3:0] FG3_PREFIX       = 4'hA;     // 0xA0 group
  localparam logic [7:0] FEAT_F13_F20     = 8'hDE;
  localparam logic [7:0] FEAT_F21_F28     = 8'hDF;

  localparam logic [2:0] PKT_SPEED = 3'd0;
  localparam logic [2:0] PKT_FG1   = 3'd1;
  localparam logic [2:0] PKT_FG2   = 3'd2;
  localparam logic [2:0] PKT_FG3   = 3'd3;
  localparam logic [2:0] PKT_FG4   = 3'd4;
  localparam logic [2:0] PKT_FG5   = 3'd5;

  typedef struct packed {
    logic [13:0]       loco_address;
    logic signed [7:0] speed_step;
    logic              forward;
    logic [28:0]       function_bits;
  } loco_req_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic [2:0] packet_number;
    logic       end_of_packet;
    logic       last;
  } pkt_word_t;

  // Classified request: address form plus every body byte that varies
  typedef struct packed {
    logic       long_addr;
    logic [7:0] addr_hi;
    logic [7:0] addr_lo;
    logic [7:0] speed_byte;
    logic [7:0] fg1_byte;
    logic [7:0] fg2_byte;
    logic [7:0] fg3_byte;
    logic [7:0] f13_byte;
    logic [7:0] f21_byte;
  } pkt_desc_t;

endpackage

@@ hw/rtl/dcc_loco_packet_builder.sv @@
// ----------------------------------------------------------------------------
// dcc_loco_packet_builder
// Turns a locomotive update request into the bytes of six DCC packets.
// ----------------------------------------------------------------------------
// Channel   Handshake     Payload     Word
// request   push / full   req         address, speed step, direction, F0..F28
// result    pop / empty   result      packet byte, packet no, eop, last
//
// One request gives 15 words (short address) or 21 words (long address).
// The back-end byte sequencer emits one word per cycle while the output
// is popped; the front takes a request every cycle until its register
// and the descriptor queue are full.
// Reset (rst, synchronous) empties the front register, queue and output.
// pop low holds the output word; the sequencer stalls, then full rises.
// ----------------------------------------------------------------------------
module dcc_loco_packet_builder
  import dcc_pkt_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  loco_req_t req,
  output logic      empty,
  input  logic      pop,
  output pkt_word_t result
);

  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;
  pkt_desc_t q_wdata;
  pkt_desc_t q_rdata;

  dcc_pkt_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .req     (req),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_wdata (q_wdata)
  );

  dcc_pkt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .full  (q_full),
    .wdata (q_wdata),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  dcc_pkt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_rdata (q_rdata),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

@@ hw/rtl/dcc_pkt_front.sv @@
// ----------------------------------------------------------------------------
// dcc_pkt_front
// Accepts requests and reduces each to a packet descriptor.
// ----------------------------------------------------------------------------
module dcc_pkt_front
  import dcc_pkt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  loco_req_t req,
  output logic      q_push,
  input  logic      q_full,
  output pkt_desc_t q_wdata
);

  logic      desc_valid;
  logic      desc_valid_next;
  pkt_desc_t desc;
  pkt_desc_t desc_next;
  logic      accept;
  logic [6:0] spd_sat;
  logic [6:0] spd_code;

  assign full   = desc_valid && q_full;
  assign accept = push && !full;

  always_comb begin
    spd_sat  = (req.speed_step[6:0] > SPEED_MAX) ? SPEED_MAX : req.speed_step[6:0];
    // step 0 stays 0, others shift up by one to skip the e-stop code
    spd_code = spd_sat + {6'd0, (spd_sat != 7'd0)};

    desc_next.long_addr  = |req.loco_address[13:7];
    desc_next.addr_hi    = LONG_ADDR_PREFIX | {2'b00, req.loco_address[13:8]};
    desc_next.addr_lo    = req.loco_address[7:0];
    desc_next.speed_byte = req.speed_step[7] ? ESTOP_BYTE : {req.forward, spd_code};
    desc_next.fg1_byte   = {FG1_PREFIX, req.function_bits[0], req.function_bits[4:1]};
    desc_next.fg2_byte   = {FG2_PREFIX, req.function_bits[8:5]};
    desc_next.fg3_byte   = {FG3_PREFIX, req.function_bits[12:9]};
    desc_next.f13_byte   = req.function_bits[20:13];
    desc_next.f21_byte   = req.function_bits[28:21];

    desc_valid_next = accept || (desc_valid && q_full);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      desc_valid <= 1'b0;
    end else begin
      desc_valid <= desc_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      desc <= desc_next;
    end
  end

  assign q_push  = desc_valid && !q_full;
  assign q_wdata = desc;

endmodule

@@ hw/rtl/dcc_pkt_queue.sv @@
// ----------------------------------------------------------------------------
// dcc_pkt_queue
// Small descriptor queue between the front and back ends.
// ----------------------------------------------------------------------------
module dcc_pkt_queue
  import dcc_pkt_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  pkt_desc_t wdata,
  input  logic      pop,
  output logic      empty,
  output pkt_desc_t rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pkt_desc_t       slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

@@ hw/rtl/dcc_pkt_back.sv @@
// ----------------------------------------------------------------------------
// dcc_pkt_back
// Byte sequencer: walks six packets of a descriptor, one word per cycle while the output slot is free.
// ----------------------------------------------------------------------------
module dcc_pkt_back
  import dcc_pkt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_empty,
  input  pkt_desc_t q_rdata,
  output logic      q_pop,
  output logic      empty,
  input  logic      pop,
  output pkt_word_t result
);

  logic      busy;
  pkt_desc_t cur;
  logic [2:0] pkt;
  logic [1:0] pos;
  logic      out_valid;
  pkt_word_t out_word;

  logic      slot_free;
  logic      emit;
  logic [1:0] addr_len;
  logic [1:0] body_len;
  logic [2:0] pkt_len;
  logic      in_body;
  logic      body_sel;
  logic [1:0] body_pos;
  logic [7:0] body_byte;
  logic      eop;
  logic      run_end;
  pkt_word_t word_next;

  assign slot_free = !out_valid || pop;
  assign emit      = busy && slot_free;
  assign run_end   = eop && (pkt == PKT_FG5);
  assign q_pop     = !q_empty && (!busy || (emit && run_end));

  always_comb begin
    addr_len = cur.long_addr ? 2'd2 : 2'd1;
    case (pkt)
      PKT_SPEED, PKT_FG4, PKT_FG5: body_len = 2'd2;
      default:                     body_len = 2'd1;
    endcase
    pkt_len  = {1'b0, addr_len} + {1'b0, body_len};
    in_body  = (pos >= addr_len);
    body_pos = pos - addr_len;
    body_sel = body_pos[0];

    case (pkt)
      PKT_SPEED: body_byte = body_sel ? cur.speed_byte : SPEED_INSTR;
      PKT_FG1:   body_byte = cur.fg1_byte;
      PKT_FG2:   body_byte = cur.fg2_byte;
      PKT_FG3:   body_byte = cur.fg3_byte;
      PKT_FG4:   body_byte = body_sel ? cur.f13_byte : FEAT_F13_F20;
      PKT_FG5:   body_byte = body_sel ? cur.f21_byte : FEAT_F21_F28;
      default:   body_byte = '0;
    endcase

    eop = ({1'b0, pos} == pkt_len - 3'd1);

    if (in_body) begin
      word_next.packet_byte = body_byte;
    end else if (cur.long_addr && pos == 2'd0) begin
      word_next.packet_byte = cur.addr_hi;
    end else begin
      word_next.packet_byte = cur.addr_lo;
    end
    word_next.packet_number = pkt;
    word_next.end_of_packet = eop;
    word_next.last          = run_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pkt       <= PKT_SPEED;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
        pkt  <= PKT_SPEED;
        pos  <= '0;
      end else if (emit) begin
        if (run_end) begin
          busy <= 1'b0;
        end else if (eop) begin
          pkt <= pkt + 3'd1;
          pos <= '0;
        end else begin
          pos <= pos + 2'd1;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_rdata;
    end
    if (emit) begin
      out_word <= word_next;
    end
  end

  assign empty  = !out_valid;
  assign result = out_word;

  a_pkt_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pkt <= PKT_FG5))
    else $error("packet counter out of range");

  a_pos_in_pkt: assert property (@(posedge clk) disable iff (rst)
    busy |-> ({1'b0, pos} < pkt_len))
    else $error("byte position past end of packet");

  a_last_marks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.last) |->
      (out_word.end_of_packet && out_word.packet_number == PKT_FG5))
    else $error("last word not closing final packet");

  a_idle_after_run: assert property (@(posedge clk) disable iff (rst)
    (emit && run_end && q_empty) |=> !busy)
    else $error("sequencer stayed busy after run");

endmodule
